/* sv/comment_strip_quoted_tokenizer_top_assert.svh */
// Assertion macros for the comment-stripping tokenizer.
`ifndef COMMENT_STRIP_QUOTED_TOKENIZER_TOP_ASSERT_SVH
`define COMMENT_STRIP_QUOTED_TOKENIZER_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define CSTOK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen.
`define CSTOK_ASSERT_NEVER(lbl, cond, msg) \
	`CSTOK_ASSERT(lbl, !(cond), msg)

`endif

/* sv/cstok_pkg.sv */
// Shared types, codes and the per-byte tokenizer step.
package cstok_pkg;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_EOL  = 1'b1;

	localparam logic [1:0] KIND_BYTE      = 2'd0;
	localparam logic [1:0] KIND_TOKEN_END = 2'd1;
	localparam logic [1:0] KIND_LINE_END  = 2'd2;

	localparam logic REG_SEP_LOW  = 1'b0;
	localparam logic REG_SEP_HIGH = 1'b1;

	// space, tab, LF, CR, ':' and ','
	localparam logic [63:0] SEP_RESET_LOW  = 64'h0400_1001_0000_2600;
	localparam logic [63:0] SEP_RESET_HIGH = 64'h0;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       first;
	} cstok_res_t;

	// All results caused by one item; cnt of zero is never queued.
	typedef struct packed {
		logic [1:0]       cnt;
		logic             conflict;
		cstok_res_t [2:0] res;
	} cstok_bundle_t;

	typedef struct packed {
		logic in_token;
		logic in_quotes;
		logic swallow;
		logic prev_bs;
	} cstok_tok_t;

	typedef struct packed {
		cstok_tok_t st;
		logic [1:0] cnt;
		cstok_res_t r0;
		cstok_res_t r1;
	} cstok_tok_out_t;

	function automatic logic is_sep(logic [7:0] b, logic [63:0] lo, logic [63:0] hi);
		if (b[7])
			return 1'b0;
		return b[6] ? hi[b[5:0]] : lo[b[5:0]];
	endfunction

	function automatic cstok_tok_out_t tokenize(cstok_tok_t st, logic [7:0] b,
			logic [63:0] lo, logic [63:0] hi);
		cstok_tok_out_t o;
		logic sep;
		o     = '0;
		o.st  = st;
		sep   = is_sep(b, lo, hi);
		if (st.swallow) begin
			o.st.swallow = 1'b0;
			o.st.prev_bs = 1'b0;
		end else if (!st.in_token) begin
			if (sep) begin
				o.st.prev_bs = (b == CH_BSLASH);
			end else begin
				o.cnt          = 2'd1;
				o.r0           = '{kind: KIND_BYTE, data: b, first: 1'b1};
				o.st.in_token  = 1'b1;
				o.st.in_quotes = (b == CH_QUOTE) && !st.prev_bs;
				o.st.prev_bs   = (b == CH_BSLASH);
			end
		end else if (sep) begin
			o.cnt = 2'd1;
			if (!st.in_quotes) begin
				o.r0          = '{kind: KIND_TOKEN_END, data: 8'h00, first: 1'b0};
				o.st.in_token = 1'b0;
				o.st.prev_bs  = 1'b0;
			end else begin
				o.r0         = '{kind: KIND_BYTE, data: b, first: 1'b0};
				o.st.prev_bs = (b == CH_BSLASH);
			end
		end else if (b == CH_QUOTE && !st.prev_bs) begin
			o.cnt = 2'd1;
			o.r0  = '{kind: KIND_BYTE, data: b, first: 1'b0};
			if (st.in_quotes) begin
				o.cnt          = 2'd2;
				o.r1           = '{kind: KIND_TOKEN_END, data: 8'h00, first: 1'b0};
				o.st.in_token  = 1'b0;
				o.st.in_quotes = 1'b0;
				o.st.swallow   = 1'b1;
			end else begin
				o.st.in_quotes = 1'b1;
			end
			o.st.prev_bs = 1'b0;
		end else begin
			o.cnt        = 2'd1;
			o.r0         = '{kind: KIND_BYTE, data: b, first: 1'b0};
			o.st.prev_bs = (b == CH_BSLASH);
		end
		return o;
	endfunction

endpackage

/* sv/cstok_front.sv */
// Front end: line cleaning, lookahead byte, tokenizer state, result bundles.
module cstok_front
	import cstok_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          action,
	input  logic [7:0]    in_byte,
	input  logic [63:0]   sep_low,
	input  logic [63:0]   sep_high,
	input  logic          q_full,
	output logic          push,
	output cstok_bundle_t bundle
);

	logic [7:0]     held_byte_q;
	logic           held_valid_q;
	cstok_tok_t     tok_q;
	logic [1:0]     bracket_run_q;
	logic           line_closed_q;
	logic           conflict_q;

	logic           accept;
	logic [7:0]     flush_byte;
	logic           ends;
	logic [1:0]     br_n;
	logic           cf_n;
	cstok_tok_out_t tok;
	logic [1:0]     tn;
	cstok_tok_t     st_after;
	cstok_res_t     end_res;
	cstok_res_t     line_res;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign end_res  = '{kind: KIND_TOKEN_END, data: 8'h00, first: 1'b0};
	assign line_res = '{kind: KIND_LINE_END, data: 8'h00, first: 1'b0};

	always_comb begin
		flush_byte = held_byte_q;
		ends       = 1'b0;
		br_n       = bracket_run_q;
		cf_n       = conflict_q;
		if (in_byte == CH_LT || in_byte == CH_GT) begin
			if (bracket_run_q != 2'd3)
				br_n = bracket_run_q + 2'd1;
			if (br_n == 2'd3)
				cf_n = 1'b1;
		end else begin
			br_n = 2'd0;
			if (in_byte == CH_HASH) begin
				// escaped hash: the held backslash turns into a space
				if (held_valid_q && held_byte_q == CH_BSLASH && action == ACT_BYTE)
					flush_byte = CH_SPACE;
				else
					ends = 1'b1;
			end
			if (in_byte == CH_NL || in_byte == CH_NUL)
				ends = 1'b1;
		end

		tok      = tokenize(tok_q, flush_byte, sep_low, sep_high);
		tn       = held_valid_q ? tok.cnt : 2'd0;
		st_after = held_valid_q ? tok.st : tok_q;

		bundle          = '0;
		bundle.res[0]   = held_valid_q ? tok.r0 : '0;
		bundle.res[1]   = held_valid_q ? tok.r1 : '0;
		if (action == ACT_EOL) begin
			bundle.conflict = conflict_q;
			case (tn)
				2'd0: begin
					if (st_after.in_token) begin
						bundle.res[0] = end_res;
						bundle.res[1] = line_res;
						bundle.cnt    = 2'd2;
					end else begin
						bundle.res[0] = line_res;
						bundle.cnt    = 2'd1;
					end
				end
				2'd1: begin
					if (st_after.in_token) begin
						bundle.res[1] = end_res;
						bundle.res[2] = line_res;
						bundle.cnt    = 2'd3;
					end else begin
						bundle.res[1] = line_res;
						bundle.cnt    = 2'd2;
					end
				end
				default: begin
					// closing quote already ended the token
					bundle.res[2] = line_res;
					bundle.cnt    = 2'd3;
				end
			endcase
		end else begin
			bundle.conflict = cf_n;
			bundle.cnt      = line_closed_q ? 2'd0 : tn;
		end
	end

	assign push = accept && (bundle.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q   <= 8'h00;
			held_valid_q  <= 1'b0;
			tok_q         <= '0;
			bracket_run_q <= 2'd0;
			line_closed_q <= 1'b0;
			conflict_q    <= 1'b0;
		end else if (accept) begin
			if (action == ACT_EOL) begin
				held_byte_q   <= 8'h00;
				held_valid_q  <= 1'b0;
				tok_q         <= '0;
				bracket_run_q <= 2'd0;
				line_closed_q <= 1'b0;
				conflict_q    <= 1'b0;
			end else if (!line_closed_q) begin
				tok_q         <= st_after;
				bracket_run_q <= br_n;
				conflict_q    <= cf_n;
				if (ends) begin
					line_closed_q <= 1'b1;
					held_valid_q  <= 1'b0;
					held_byte_q   <= 8'h00;
				end else begin
					held_valid_q  <= 1'b1;
					held_byte_q   <= in_byte;
				end
			end
		end
	end

endmodule

/* sv/cstok_queue.sv */
// Bundle queue between front and back end.
module cstok_queue
	import cstok_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cstok_bundle_t wdata,
	input  logic          pop,
	output cstok_bundle_t rdata,
	output logic          nonempty,
	output logic          full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cstok_bundle_t  mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign nonempty = (count_q != '0);
	assign full     = (count_q == CW'(DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rdata    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

/* sv/cstok_back.sv */
// Back end: walks each bundle one result a cycle into the output register while out_stall is low.
module cstok_back
	import cstok_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cstok_bundle_t head,
	input  logic          head_valid,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    kind,
	output logic [7:0]    out_byte,
	output logic          token_first,
	output logic          conflict_marker,
	output logic          last
);

	logic [1:0]  idx_q;
	logic        out_valid_q;
	cstok_res_t  res_q;
	logic        conflict_q;
	logic        last_q;

	logic        load;
	logic        is_last;
	cstok_res_t  cur;

	always_comb begin
		case (idx_q)
			2'd0:    cur = head.res[0];
			2'd1:    cur = head.res[1];
			default: cur = head.res[2];
		endcase
	end

	assign load    = head_valid && (!out_valid_q || !out_stall);
	assign is_last = (idx_q == 2'(head.cnt - 2'd1));
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q      <= cur;
			conflict_q <= head.conflict;
			last_q     <= is_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = res_q.kind;
	assign out_byte        = res_q.data;
	assign token_first     = res_q.first;
	assign conflict_marker = conflict_q;
	assign last            = last_q;

endmodule

/* sv/comment_strip_quoted_tokenizer_top.sv */
// Top level of the comment-stripping, quote-aware line tokenizer.
//
//  channel  dir  handshake           payload
//  in       in   in_valid/in_stall   action, in_byte
//  out      out  out_valid/out_stall kind, out_byte, token_first, conflict_marker, last
//  cfg      in   cfg_we              cfg_index, cfg_data (write only)
//
// An input item is taken every cycle while the bundle queue has room; the front end
// works out all results of an item in the cycle it is taken.
// The back end sends one result a cycle while out_stall is low; items with no result
// (held bytes, stripped bytes) are not queued and take no output time.
// The QUEUE_DEPTH-entry bundle queue lets either side stall without holding the other.
// Reset clears all line state and loads the default separator masks; no clearing pass.
// in_stall is high only while the queue is full; out_stall holds the output register.
module comment_strip_quoted_tokenizer_top
	import cstok_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic        token_first,
	output logic        conflict_marker,
	output logic        last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	`include "comment_strip_quoted_tokenizer_top_assert.svh"

	// separator masks, one bit per byte value below 128
	logic [63:0]   sep_low_q;
	logic [63:0]   sep_high_q;

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_nonempty;
	cstok_bundle_t q_wdata;
	cstok_bundle_t q_head;

	// a marker result that carries data or the first-byte flag
	logic          marker_dirty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_low_q  <= SEP_RESET_LOW;
			sep_high_q <= SEP_RESET_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEP_LOW:  sep_low_q  <= cfg_data;
				REG_SEP_HIGH: sep_high_q <= cfg_data;
				default:      sep_low_q  <= sep_low_q;
			endcase
		end
	end

	// front end: cleaning and tokenizing, at most one bundle of results per item
	cstok_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.in_byte  (in_byte),
		.sep_low  (sep_low_q),
		.sep_high (sep_high_q),
		.q_full   (q_full),
		.push     (q_push),
		.bundle   (q_wdata)
	);

	cstok_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.pop      (q_pop),
		.rdata    (q_head),
		.nonempty (q_nonempty),
		.full     (q_full)
	);

	// back end: serialises each bundle through the output register
	cstok_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (q_head),
		.head_valid      (q_nonempty),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.out_byte        (out_byte),
		.token_first     (token_first),
		.conflict_marker (conflict_marker),
		.last            (last)
	);

	assign marker_dirty = (kind != KIND_BYTE) && (out_byte != 8'h00 || token_first);

	// a line end is always the final result of its item
	`CSTOK_ASSERT(a_line_end_last, (out_valid && kind == KIND_LINE_END) |-> last, "line end not last")
	// only token bytes carry data or the first-byte flag
	`CSTOK_ASSERT_NEVER(a_marker_clean, out_valid && marker_dirty, "marker result carries data")
	// the back end never drains an empty queue
	`CSTOK_ASSERT(a_pop_nonempty, q_pop |-> q_nonempty, "pop from empty queue")

endmodule

/* bench/comment_strip_quoted_tokenizer_top_test.sv */
// Self-checking bench for the comment-stripping, quote-aware line tokenizer.
module comment_strip_quoted_tokenizer_top_test;
	import cstok_pkg::*;

	// Longest stretch with no item accepted on either side before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 1000;
	// Cycles of quiet after the last result: bundle queue plus output register, with margin.
	localparam int QUIET_CYCLES   = 16;
	// Length of the one long receiver hold-off.
	localparam int LONG_HOLD      = 80;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LOW_A = 8'h61;

	typedef struct packed {
		logic       act;
		logic [7:0] b;
	} line_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       first;
		logic       conflict;
		logic       last;
	} token_result_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        action    = ACT_BYTE;
	logic [7:0]  in_byte   = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic        token_first;
	logic        conflict_marker;
	logic        last;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = REG_SEP_LOW;
	logic [63:0] cfg_data  = '0;

	comment_strip_quoted_tokenizer_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.in_byte         (in_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.out_byte        (out_byte),
		.token_first     (token_first),
		.conflict_marker (conflict_marker),
		.last            (last),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Line model: separator masks and per-line state, updated blocking
	// from the monitor as items and register writes are seen at the edge.
	// ------------------------------------------------------------------
	logic [63:0] sep_lo_m, sep_hi_m;
	logic [7:0]  hold_b;
	logic        hold_v, tok_open, quoted, skip_next, after_bs, line_done, conflict_m;
	logic [1:0]  angle_run;

	token_result_t step_out[$];        // results of the item being modelled
	token_result_t expected_tokens[$]; // results still owed by the block
	line_item_t    line_items[$];      // items waiting for the driver

	int mismatches, results_checked, lines_seen, token_ends, conflict_results;
	int items_accepted, mask_writes, queued_items;

	function automatic logic sep_hit(logic [7:0] b);
		if (b < 8'd64)
			return sep_lo_m[b[5:0]];
		if (b < 8'd128)
			return sep_hi_m[b[5:0]];
		return 1'b0; // top half of the byte range never splits
	endfunction

	function automatic void put_result(logic [1:0] k, logic [7:0] d, logic f);
		token_result_t r;
		r.kind     = k;
		r.data     = d;
		r.first    = f;
		r.conflict = conflict_m;
		r.last     = 1'b0;
		step_out.push_back(r);
	endfunction

	// One cleaned byte into the token splitter.
	function automatic void split_byte(logic [7:0] b);
		logic is_s;
		is_s = sep_hit(b);
		if (skip_next) begin
			// byte after a closing quote vanishes and breaks any escape
			skip_next = 1'b0;
			after_bs  = 1'b0;
		end else if (!tok_open) begin
			if (!is_s) begin
				put_result(KIND_BYTE, b, 1'b1);
				tok_open = 1'b1;
				quoted   = (b == CH_QUOTE) && !after_bs;
			end
			after_bs = (b == CH_BSLASH);
		end else if (is_s && !quoted) begin
			put_result(KIND_TOKEN_END, 8'h00, 1'b0);
			tok_open = 1'b0;
			after_bs = 1'b0;
		end else if (!is_s && b == CH_QUOTE && !after_bs) begin
			put_result(KIND_BYTE, b, 1'b0);
			if (quoted) begin
				put_result(KIND_TOKEN_END, 8'h00, 1'b0);
				tok_open  = 1'b0;
				quoted    = 1'b0;
				skip_next = 1'b1;
			end else begin
				quoted = 1'b1;
			end
			after_bs = 1'b0;
		end else begin
			put_result(KIND_BYTE, b, 1'b0);
			after_bs = (b == CH_BSLASH);
		end
	endfunction

	function automatic void release_held();
		if (hold_v) begin
			split_byte(hold_b);
			hold_v = 1'b0;
			hold_b = 8'h00;
		end
	endfunction

	function automatic void clear_line();
		hold_b    = 8'h00;
		hold_v    = 1'b0;
		tok_open  = 1'b0;
		quoted    = 1'b0;
		skip_next = 1'b0;
		after_bs  = 1'b0;
		angle_run = 2'd0;
		line_done = 1'b0;
		conflict_m = 1'b0;
	endfunction

	// Works out every result of one accepted item and queues them.
	function automatic void token_stream_step(logic act, logic [7:0] b);
		logic          ends;
		token_result_t r;
		step_out.delete();
		ends = 1'b0;
		if (act == ACT_EOL) begin
			release_held();
			if (tok_open)
				put_result(KIND_TOKEN_END, 8'h00, 1'b0);
			put_result(KIND_LINE_END, 8'h00, 1'b0);
			clear_line();
		end else if (!line_done) begin
			if (b == CH_LT || b == CH_GT) begin
				if (angle_run != 2'd3)
					angle_run = angle_run + 2'd1;
				if (angle_run == 2'd3)
					conflict_m = 1'b1;
			end else begin
				angle_run = 2'd0;
				if (b == CH_HASH) begin
					// escaped hash: the held backslash turns into a space
					if (hold_v && hold_b == CH_BSLASH)
						hold_b = CH_SPACE;
					else
						ends = 1'b1;
				end
				if (b == CH_NL || b == CH_NUL)
					ends = 1'b1;
			end
			release_held();
			if (ends) begin
				line_done = 1'b1;
			end else begin
				hold_b = b;
				hold_v = 1'b1;
			end
		end
		foreach (step_out[i]) begin
			r      = step_out[i];
			r.last = (i == step_out.size() - 1);
			expected_tokens.push_back(r);
		end
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: checks results, models accepted items and register writes,
	// and runs the watchdog.
	// ------------------------------------------------------------------
	int idle_cycles;

	always @(posedge clk) begin : watch_outputs
		token_result_t want;
		logic          moved;
		if (!arst_n) begin
			sep_lo_m    = SEP_RESET_LOW;
			sep_hi_m    = SEP_RESET_HIGH;
			clear_line();
			idle_cycles = 0;
		end else begin
			moved = 1'b0;
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected result, expected none, got kind %0d byte %0h",
						$time, kind, out_byte);
					mismatches++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("kind", want.kind, kind);
					check_field("out_byte", want.data, out_byte);
					check_field("token_first", want.first, token_first);
					check_field("conflict_marker", want.conflict, conflict_marker);
					check_field("last", want.last, last);
					results_checked++;
					if (want.kind == KIND_TOKEN_END)
						token_ends++;
					if (want.conflict)
						conflict_results++;
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				items_accepted++;
				if (action == ACT_EOL)
					lines_seen++;
				token_stream_step(action, in_byte);
			end
			if (cfg_we) begin
				if (cfg_index == REG_SEP_LOW)
					sep_lo_m = cfg_data;
				else
					sep_hi_m = cfg_data;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("comment_strip_quoted_tokenizer_top test failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver: bursts of random length, random gaps, payload held while stalled.
	// ------------------------------------------------------------------
	int burst_left, gap_left;

	always @(posedge clk) begin : drive_items
		line_item_t it;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			action     <= ACT_BYTE;
			in_byte    <= 8'h00;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (line_items.size() != 0) begin
				it       = line_items.pop_front();
				in_valid <= 1'b1;
				action   <= it.act;
				in_byte  <= it.b;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					// about a third of bursts run straight into the next
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall patterns of random length, plus one long hold-off
	// on request so the bundle queue fills and the input stalls.
	// ------------------------------------------------------------------
	logic       long_hold_req = 1'b0;
	logic       long_hold_taken;
	int         long_hold_left, pattern_left;
	logic [1:0] stall_pattern;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall       <= 1'b0;
			long_hold_taken <= 1'b0;
			long_hold_left  <= 0;
			pattern_left    <= 0;
			stall_pattern   <= 2'd0;
		end else if (long_hold_req && !long_hold_taken) begin
			long_hold_taken <= 1'b1;
			long_hold_left  <= LONG_HOLD;
			out_stall       <= 1'b1;
		end else if (long_hold_left != 0) begin
			long_hold_left <= long_hold_left - 1;
			out_stall      <= (long_hold_left != 1);
		end else begin
			if (pattern_left == 0) begin
				stall_pattern <= 2'($urandom_range(0, 3));
				pattern_left  <= $urandom_range(8, 48);
			end else begin
				pattern_left <= pattern_left - 1;
			end
			case (stall_pattern)
				2'd0: out_stall <= 1'b0;
				2'd1: out_stall <= ($urandom_range(0, 3) == 0);
				2'd2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic void queue_item(logic act, logic [7:0] b);
		line_item_t it;
		it.act = act;
		it.b   = b;
		line_items.push_back(it);
		queued_items++;
	endfunction

	function automatic void queue_eol();
		queue_item(ACT_EOL, 8'($urandom_range(0, 255))); // byte is don't-care
	endfunction

	function automatic logic [7:0] pick_separator();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_COLON;
			default: return CH_COMMA;
		endcase
	endfunction

	function automatic logic [7:0] pick_letter();
		return CH_LOW_A + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] pick_noise_byte();
		case ($urandom_range(0, 15))
			0, 1, 2, 3: return pick_letter();
			4, 5:       return pick_separator();
			6, 7:       return CH_QUOTE;
			8:          return CH_BSLASH;
			9, 10:      return ($urandom_range(0, 1) != 0) ? CH_LT : CH_GT;
			11:         return CH_HASH;
			12:         return ($urandom_range(0, 1) != 0) ? CH_NL : CH_NUL;
			13:         return 8'($urandom_range(128, 255));
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// A line built from words: plain, quoted, angle runs, escapes, noise.
	function automatic void queue_word_line();
		int words;
		words = $urandom_range(0, 5);
		repeat (words) begin
			case ($urandom_range(0, 6))
				0, 1: repeat ($urandom_range(1, 5)) queue_item(ACT_BYTE, pick_letter());
				2: begin
					queue_item(ACT_BYTE, CH_QUOTE);
					repeat ($urandom_range(0, 4))
						queue_item(ACT_BYTE, ($urandom_range(0, 2) == 0) ?
							pick_separator() : pick_letter());
					if ($urandom_range(0, 3) != 0)
						queue_item(ACT_BYTE, CH_QUOTE);
					queue_item(ACT_BYTE, pick_letter()); // swallowed after a close
				end
				3: repeat ($urandom_range(2, 4))
					queue_item(ACT_BYTE, ($urandom_range(0, 1) != 0) ? CH_LT : CH_GT);
				4: begin
					queue_item(ACT_BYTE, CH_BSLASH);
					queue_item(ACT_BYTE, ($urandom_range(0, 1) != 0) ? CH_HASH : CH_QUOTE);
				end
				5: queue_item(ACT_BYTE, 8'($urandom_range(128, 255)));
				default: queue_item(ACT_BYTE, pick_noise_byte());
			endcase
			queue_item(ACT_BYTE, pick_separator());
		end
		// trailing comment, with text behind it that must vanish
		if ($urandom_range(0, 4) == 0) begin
			queue_item(ACT_BYTE, CH_HASH);
			repeat ($urandom_range(0, 3)) queue_item(ACT_BYTE, pick_noise_byte());
		end
		queue_eol();
	endfunction

	function automatic void queue_noise_line();
		repeat ($urandom_range(0, 12)) queue_item(ACT_BYTE, pick_noise_byte());
		queue_eol();
	endfunction

	function automatic void queue_random_lines(int count);
		int goal;
		goal = queued_items + count;
		while (queued_items < goal) begin
			if ($urandom_range(0, 3) == 0)
				queue_noise_line();
			else
				queue_word_line();
		end
	endfunction

	// Sender pause: everything sent, every result back, block given time to settle.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (line_items.size() != 0 || in_valid || expected_tokens.size() != 0);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_sep_masks(logic [63:0] lo, logic [63:0] hi);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SEP_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_SEP_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mask_writes += 2;
		@(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Quote at line start opens quotes, separator kept inside, closing quote
		// ends the token and swallows the next byte; bare hash ends the line.
		queue_item(ACT_BYTE, CH_QUOTE);
		queue_item(ACT_BYTE, CH_LOW_A);
		queue_item(ACT_BYTE, CH_SPACE);
		queue_item(ACT_BYTE, CH_LOW_A + 8'd1);
		queue_item(ACT_BYTE, CH_QUOTE);
		queue_item(ACT_BYTE, CH_LOW_A + 8'd2);
		queue_item(ACT_BYTE, CH_HASH);
		queue_eol();
		// Closing quote still held at end of line: three results on one item,
		// and the pending swallow is dropped.
		queue_item(ACT_BYTE, CH_QUOTE);
		queue_item(ACT_BYTE, CH_LOW_A + 8'd23);
		queue_item(ACT_BYTE, CH_QUOTE);
		queue_eol();
		// Escaped hash becomes a space, angle run sets the conflict flag,
		// zero byte ends the line and what follows is ignored.
		queue_item(ACT_BYTE, CH_BSLASH);
		queue_item(ACT_BYTE, CH_HASH);
		queue_item(ACT_BYTE, CH_LT);
		queue_item(ACT_BYTE, CH_LT);
		queue_item(ACT_BYTE, CH_LT);
		queue_item(ACT_BYTE, CH_LOW_A + 8'd16);
		queue_item(ACT_BYTE, CH_NUL);
		queue_item(ACT_BYTE, CH_LOW_A + 8'd25);
		queue_eol();
		// Separator after a backslash token clears the escape, so the quote
		// opens; top byte is a token byte; newline ends the line with quote open.
		queue_item(ACT_BYTE, CH_BSLASH);
		queue_item(ACT_BYTE, CH_SPACE);
		queue_item(ACT_BYTE, CH_QUOTE);
		queue_item(ACT_BYTE, 8'hFF);
		queue_item(ACT_BYTE, CH_NL);
		queue_eol();

		queue_random_lines(15);
		wait_quiet();

		// every byte below 128 splits
		write_sep_masks('1, '1);
		queue_random_lines(15);
		wait_quiet();

		// nothing splits
		write_sep_masks('0, '0);
		queue_random_lines(15);
		wait_quiet();

		// random masks, with the long receiver hold-off against a busy sender
		write_sep_masks({32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)});
		long_hold_req = 1'b1;
		queue_random_lines(20);
		wait_quiet();

		write_sep_masks(SEP_RESET_LOW, SEP_RESET_HIGH);
		queue_random_lines(20);
		wait_quiet();

		$display("Covered %0d items over %0d lines, %0d results checked (%0d token ends).",
			items_accepted, lines_seen, results_checked, token_ends);
		$display("%0d results under a conflict flag, %0d mask writes, %0d mismatches.",
			conflict_results, mask_writes, mismatches);
		if (mismatches == 0)
			$display("comment_strip_quoted_tokenizer_top test passed");
		else
			$display("comment_strip_quoted_tokenizer_top test failed");
		$finish;
	end

endmodule
